// ===== rtl/core/cqbs_pkg.sv =====
// Shared types, codes and reset values for the calendar queue band scheduler.
`timescale 1ns / 1ps
package cqbs_pkg;

	// Default build sizes.
	localparam int MAX_BANDS_DEF  = 256;
	localparam int FIFO_DEPTH_DEF = 64;

	// Budget counter width: a band budget plus one packet length.
	localparam int BUDGET_W = 37;

	// Shared divider operand widths.
	localparam int DIV_NW = 41;
	localparam int DIV_DW = 32;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 36;

	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_PREFILL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_OTHER   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_COUNT   = 3'd4;

	// Register reset values.
	localparam logic [31:0] RST_INTERVAL     = 32'd1000000;
	localparam logic [35:0] RST_MAX_BYTES    = 36'd5120000000;
	localparam logic [15:0] RST_RATE_PREFILL = 16'd250;
	localparam logic [15:0] RST_RATE_OTHER   = 16'd20;
	localparam logic [8:0]  RST_BAND_COUNT   = 9'd200;

	// Request modes.
	localparam logic [1:0] MODE_ENQ  = 2'd0;
	localparam logic [1:0] MODE_DEQ  = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;
	localparam logic [1:0] MODE_NONE = 2'd3;

	// Flow classes.
	localparam logic [1:0] CLASS_UNTAGGED = 2'd0;
	localparam logic [1:0] CLASS_PREFILL  = 2'd1;
	localparam logic [1:0] CLASS_DECODE   = 2'd2;

	// Result status codes.
	localparam logic [2:0] STATUS_ENQUEUED = 3'd0;
	localparam logic [2:0] STATUS_REJECTED = 3'd1;
	localparam logic [2:0] STATUS_DEQUEUED = 3'd2;
	localparam logic [2:0] STATUS_EMPTY    = 3'd3;
	localparam logic [2:0] STATUS_ROTATED  = 3'd4;

	typedef struct packed {
		logic [1:0]  mode;
		logic [1:0]  flow_class;
		logic [15:0] packet_bytes;
		logic [15:0] packet_handle;
		logic [39:0] deadline_us;
		logic [39:0] accrued_delay_us;
		logic [39:0] time_now_us;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  band;
		logic [15:0] out_handle;
		logic [15:0] out_bytes;
	} rsp_t;

endpackage

// ===== rtl/core/calendar_queue_band_scheduler.sv =====
// Top level of the calendar queue band scheduler: sequencer, registers and memories.
`timescale 1ns / 1ps
// Usage
// Requests arrive on req (valid/ready) and carry a mode: enqueue, dequeue or
// rotation tick. Each request except the unused mode returns one response on
// rsp (valid/ready). Configuration writes use cfg (valid/ready, index, data);
// cfg_ready is always high and writes belong in idle periods.
// The block works on one request at a time. A tick goes from dispatch to the
// band write and then to the finish state, which loads the response register.
// A dequeue reads and evaluates each band in turn, and adds a descriptor read
// when a packet is found. An enqueue passes through a prepare state before the
// same scan; a decode enqueue with slack first runs the shared bit-serial
// divider twice (slack, then start band modulo band count). When
// band_count has been lowered to or below the current band, one more divider
// run reduces the current band first. The next request can be taken in the
// cycle after the response register loads.
// The band scan walks the band memory, whose single read port sets the pace.
// A finished response sits in an output register; the next request is taken
// while it waits, and a later response holds in the sequencer until the
// receiver takes the earlier one. Reset clears the registers and the band
// valid bits, so every band reads as empty at once with no clearing pass.
module calendar_queue_band_scheduler #(
	parameter int MAX_BANDS  = cqbs_pkg::MAX_BANDS_DEF,
	parameter int FIFO_DEPTH = cqbs_pkg::FIFO_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  cqbs_pkg::req_t                 req,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output cqbs_pkg::rsp_t                 rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cqbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cqbs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cqbs_pkg::*;

	localparam int BW  = $clog2(MAX_BANDS);
	localparam int NW  = $clog2(MAX_BANDS + 1);
	localparam int PW  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FW  = $clog2(FIFO_DEPTH + 1);
	localparam int QW  = 16 + FW;
	localparam int EW  = BUDGET_W + QW + 2 * PW + FW;
	localparam int DAW = $clog2(MAX_BANDS * FIFO_DEPTH);

	typedef struct packed {
		logic [BUDGET_W-1:0] budget;
		logic [QW-1:0]       queued;
		logic [PW-1:0]       head;
		logic [PW-1:0]       tail;
		logic [FW-1:0]       fill;
	} band_ent_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_NORM,
		S_DISP,
		S_SLACK,
		S_MODW,
		S_PREP,
		S_RD,
		S_EV,
		S_DRD,
		S_TWR,
		S_FIN
	} state_t;

	// Configuration registers.
	logic [31:0] interval_q;
	logic [35:0] max_bytes_q;
	logic [15:0] rate_prefill_q;
	logic [15:0] rate_other_q;
	logic [8:0]  band_count_q;

	// Scheduler state and per-request registers.
	state_t          state_q;
	logic [BW-1:0]   current_band_q;
	logic [39:0]     rot_start_q;
	req_t            item_q;
	logic [NW-1:0]   n_q;
	logic [BW-1:0]   cur_q;
	logic [BW-1:0]   b_q;
	logic [NW-1:0]   cnt_q;
	logic [31:0]     remain_q;
	logic [47:0]     allow_q;
	rsp_t            res_q;
	logic            rsp_valid_q;
	rsp_t            rsp_q;

	// Combinational helpers.
	logic [NW-1:0]       n_c;
	logic [31:0]         interval_eff;
	logic [39:0]         elapsed;
	logic [31:0]         remain_c;
	logic [15:0]         rate;
	logic                has_slack;
	logic [NW-1:0]       nb_sum;
	logic [BW-1:0]       next_b;
	logic                scan_last;
	band_ent_t           ent;
	band_ent_t           wr_ent;
	logic [BUDGET_W-1:0] budget_sum;
	logic [47:0]         need;
	logic                fit;
	logic [PW:0]         tail_inc;
	logic [PW:0]         head_inc;
	logic [DIV_NW-1:0]   offset;

	// Memory and divider hookup.
	logic              bm_rd_en;
	logic [EW-1:0]     bm_rd_data;
	logic              bm_wr_en;
	logic              dm_rd_en;
	logic [DAW-1:0]    dm_rd_addr;
	logic [31:0]       dm_rd_data;
	logic              dm_wr_en;
	logic [DAW-1:0]    dm_wr_addr;
	logic              div_start;
	logic [DIV_NW-1:0] div_dividend;
	logic [DIV_DW-1:0] div_divisor;
	logic              div_done;
	logic [DIV_NW-1:0] div_quo;
	logic [DIV_DW-1:0] div_rem;

	// Bands in use, clamped to at least two and at most the built range.
	always_comb begin
		if (band_count_q < 9'd2) begin
			n_c = NW'(2);
		end else if (32'(band_count_q) > 32'(MAX_BANDS)) begin
			n_c = NW'(MAX_BANDS);
		end else begin
			n_c = NW'(band_count_q);
		end
	end

	// Time left in the current rotation and the drain rate of this class.
	always_comb begin
		interval_eff = (interval_q == 32'd0) ? 32'd1 : interval_q;
		elapsed      = (item_q.time_now_us > rot_start_q) ?
			item_q.time_now_us - rot_start_q : 40'd0;
		remain_c     = (elapsed < {8'd0, interval_eff}) ?
			32'({8'd0, interval_eff} - elapsed) : 32'd0;
		rate         = (item_q.flow_class == CLASS_PREFILL) ? rate_prefill_q : rate_other_q;
		has_slack    = (item_q.flow_class == CLASS_DECODE) &&
			(item_q.deadline_us > item_q.accrued_delay_us);
		offset       = (div_quo == '0) ? '0 : div_quo - DIV_NW'(1);
	end

	// Scan position stepping with wrap at the band count.
	always_comb begin
		nb_sum    = NW'(b_q) + NW'(1);
		next_b    = (nb_sum == n_q) ? '0 : BW'(nb_sum);
		scan_last = (cnt_q + NW'(1)) == n_q;
	end

	// Fit test for the band under examination.
	always_comb begin
		ent        = band_ent_t'(bm_rd_data);
		budget_sum = ent.budget + BUDGET_W'(item_q.packet_bytes);
		need       = 48'(item_q.packet_bytes) + 48'(ent.queued);
		fit        = (ent.fill < FW'(FIFO_DEPTH)) &&
			(budget_sum <= BUDGET_W'(max_bytes_q)) &&
			((b_q != cur_q) || (need <= allow_q));
		tail_inc   = (PW + 1)'(ent.tail) + (PW + 1)'(1);
		head_inc   = (PW + 1)'(ent.head) + (PW + 1)'(1);
	end

	// Updated band entry for enqueue, dequeue and tick.
	always_comb begin
		wr_ent = ent;
		unique case (state_q)
			S_EV: begin
				wr_ent.tail   = (tail_inc == (PW + 1)'(FIFO_DEPTH)) ? '0 : PW'(tail_inc);
				wr_ent.fill   = ent.fill + FW'(1);
				wr_ent.queued = ent.queued + QW'(item_q.packet_bytes);
				wr_ent.budget = budget_sum;
			end
			S_DRD: begin
				wr_ent.head   = (head_inc == (PW + 1)'(FIFO_DEPTH)) ? '0 : PW'(head_inc);
				wr_ent.fill   = ent.fill - FW'(1);
				wr_ent.queued = (ent.queued >= QW'(dm_rd_data[15:0])) ?
					ent.queued - QW'(dm_rd_data[15:0]) : '0;
			end
			S_TWR: begin
				wr_ent.budget = '0;
			end
			default: begin
				wr_ent = ent;
			end
		endcase
	end

	// Memory strobes follow the sequencer state; one access to a band at a time.
	always_comb begin
		bm_rd_en   = (state_q == S_RD) ||
			((state_q == S_DISP) && (item_q.mode == MODE_TICK));
		bm_wr_en   = ((state_q == S_EV) && (item_q.mode == MODE_ENQ) && fit) ||
			(state_q == S_DRD) || (state_q == S_TWR);
		dm_wr_en   = (state_q == S_EV) && (item_q.mode == MODE_ENQ) && fit;
		dm_rd_en   = (state_q == S_EV) && (item_q.mode == MODE_DEQ) && (ent.fill != '0);
		dm_wr_addr = DAW'(b_q) * DAW'(FIFO_DEPTH) + DAW'(ent.tail);
		dm_rd_addr = DAW'(b_q) * DAW'(FIFO_DEPTH) + DAW'(ent.head);
	end

	// Divider requests: current band reduction, slack, start band modulo.
	always_comb begin
		div_start    = 1'b0;
		div_dividend = DIV_NW'(current_band_q);
		div_divisor  = DIV_DW'(n_c);
		unique case (state_q)
			S_IDLE: begin
				div_start = req_valid && (req.mode != MODE_NONE) &&
					(NW'(current_band_q) >= n_c);
			end
			S_DISP: begin
				div_start    = (item_q.mode == MODE_ENQ) && has_slack;
				div_dividend = DIV_NW'(item_q.deadline_us - item_q.accrued_delay_us);
				div_divisor  = interval_eff;
			end
			S_SLACK: begin
				div_start    = div_done;
				div_dividend = offset + DIV_NW'(cur_q);
				div_divisor  = DIV_DW'(n_q);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q     <= RST_INTERVAL;
			max_bytes_q    <= RST_MAX_BYTES;
			rate_prefill_q <= RST_RATE_PREFILL;
			rate_other_q   <= RST_RATE_OTHER;
			band_count_q   <= RST_BAND_COUNT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_INTERVAL:     interval_q     <= cfg_data[31:0];
				REG_MAX_BYTES:    max_bytes_q    <= cfg_data[35:0];
				REG_RATE_PREFILL: rate_prefill_q <= cfg_data[15:0];
				REG_RATE_OTHER:   rate_other_q   <= cfg_data[15:0];
				REG_BAND_COUNT:   band_count_q   <= cfg_data[8:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer with its registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			current_band_q <= '0;
			rot_start_q    <= '0;
			rsp_valid_q    <= 1'b0;
			item_q         <= '0;
			n_q            <= '0;
			cur_q          <= '0;
			b_q            <= '0;
			cnt_q          <= '0;
			remain_q       <= '0;
			allow_q        <= '0;
			res_q          <= '0;
			rsp_q          <= '0;
		end else begin
			// The finish state reloads the response register itself.
			if (rsp_valid_q && rsp_ready && (state_q != S_FIN)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid && (req.mode != MODE_NONE)) begin
						item_q <= req;
						n_q    <= n_c;
						if (NW'(current_band_q) < n_c) begin
							cur_q   <= current_band_q;
							b_q     <= current_band_q;
							state_q <= S_DISP;
						end else begin
							state_q <= S_NORM;
						end
					end
				end
				S_NORM: begin
					if (div_done) begin
						cur_q   <= BW'(div_rem);
						b_q     <= BW'(div_rem);
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					remain_q <= remain_c;
					cnt_q    <= '0;
					unique case (item_q.mode)
						MODE_TICK: state_q <= S_TWR;
						MODE_DEQ:  state_q <= S_RD;
						MODE_ENQ:  state_q <= has_slack ? S_SLACK : S_PREP;
						default:   state_q <= S_IDLE;
					endcase
				end
				S_SLACK: begin
					if (div_done) begin
						state_q <= S_MODW;
					end
				end
				S_MODW: begin
					if (div_done) begin
						b_q     <= BW'(div_rem);
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					allow_q <= 48'(remain_q) * 48'(rate);
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_EV;
				end
				S_EV: begin
					if (item_q.mode == MODE_ENQ && fit) begin
						res_q   <= '{status: STATUS_ENQUEUED, band: 8'(b_q),
							out_handle: 16'd0, out_bytes: 16'd0};
						state_q <= S_FIN;
					end else if (item_q.mode == MODE_DEQ && ent.fill != '0) begin
						state_q <= S_DRD;
					end else if (scan_last) begin
						res_q   <= '{status: (item_q.mode == MODE_ENQ) ?
							STATUS_REJECTED : STATUS_EMPTY,
							band: 8'd0, out_handle: 16'd0, out_bytes: 16'd0};
						state_q <= S_FIN;
					end else begin
						b_q     <= next_b;
						cnt_q   <= cnt_q + NW'(1);
						state_q <= S_RD;
					end
				end
				S_DRD: begin
					res_q   <= '{status: STATUS_DEQUEUED, band: 8'(b_q),
						out_handle: dm_rd_data[31:16], out_bytes: dm_rd_data[15:0]};
					state_q <= S_FIN;
				end
				S_TWR: begin
					rot_start_q    <= item_q.time_now_us;
					current_band_q <= next_b;
					res_q          <= '{status: STATUS_ROTATED, band: 8'(next_b),
						out_handle: 16'd0, out_bytes: 16'd0};
					state_q        <= S_FIN;
				end
				S_FIN: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	cqbs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	cqbs_band_mem #(
		.DEPTH (MAX_BANDS),
		.EW    (EW),
		.AW    (BW)
	) u_band_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (bm_rd_en),
		.rd_addr (b_q),
		.rd_data (bm_rd_data),
		.wr_en   (bm_wr_en),
		.wr_addr (b_q),
		.wr_data (EW'(wr_ent))
	);

	cqbs_desc_mem #(
		.DEPTH (MAX_BANDS * FIFO_DEPTH),
		.AW    (DAW)
	) u_desc_mem (
		.clk     (clk),
		.rd_en   (dm_rd_en),
		.rd_addr (dm_rd_addr),
		.rd_data (dm_rd_data),
		.wr_en   (dm_wr_en),
		.wr_addr (dm_wr_addr),
		.wr_data ({item_q.packet_handle, item_q.packet_bytes})
	);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

endmodule

// ===== rtl/core/cqbs_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by slack and modulo work.
`timescale 1ns / 1ps
module cqbs_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [cqbs_pkg::DIV_NW-1:0] dividend,
	input  logic [cqbs_pkg::DIV_DW-1:0] divisor,
	output logic                       done,
	output logic [cqbs_pkg::DIV_NW-1:0] quotient,
	output logic [cqbs_pkg::DIV_DW-1:0] remainder
);
	import cqbs_pkg::*;

	localparam int CNT_W = $clog2(DIV_NW + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] div_q;
	logic [DIV_DW:0]   trial;
	logic              ge;
	logic [DIV_DW-1:0] rem_n;

	// One restoring step: shift in the next dividend bit and try a subtract.
	always_comb begin
		trial = {rem_q, quo_q[DIV_NW-1]};
		ge    = trial >= {1'b0, div_q};
		rem_n = ge ? DIV_DW'(trial - {1'b0, div_q}) : DIV_DW'(trial);
	end

	// Control: step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_NW-2:0], ge};
			rem_q <= rem_n;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/core/cqbs_band_mem.sv =====
// Per-band state memory with valid bits so unwritten bands read as zero.
`timescale 1ns / 1ps
module cqbs_band_mem #(
	parameter int DEPTH = 256,
	parameter int EW    = 78,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [EW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [EW-1:0] wr_data
);
	import cqbs_pkg::*;

	logic [EW-1:0]    mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [EW-1:0]    rd_raw_q;
	logic             rd_valid_q;

	// Storage array with registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q <= mem[rd_addr];
		end
	end

	// Valid bits are cleared at reset and set by the first write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_raw_q : '0;

endmodule

// ===== rtl/core/cqbs_desc_mem.sv =====
// Descriptor store: handle and length of every queued packet.
`timescale 1ns / 1ps
module cqbs_desc_mem #(
	parameter int DEPTH = 16384,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [31:0]   rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [31:0]   wr_data
);
	import cqbs_pkg::*;

	logic [31:0] mem [DEPTH];
	logic [31:0] rd_q;

	// Single write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ===== rtl/core/cqbs_checker.sv =====
// Port-level checks for the calendar queue band scheduler, bound to the top level.
`timescale 1ns / 1ps
module cqbs_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input cqbs_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input cqbs_pkg::rsp_t rsp
);
	import cqbs_pkg::*;

	// A stalled response holds its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// Only a dequeue response carries a descriptor.
	a_rsp_no_desc: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != STATUS_DEQUEUED) |->
		(rsp.out_handle == 16'd0) && (rsp.out_bytes == 16'd0))
		else $error("descriptor fields set on a non-dequeue response");

	// Rejected and empty responses report band zero.
	a_rsp_band_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ((rsp.status == STATUS_REJECTED) || (rsp.status == STATUS_EMPTY)) |->
		(rsp.band == 8'd0))
		else $error("failed request reports a band");

	// A request that does work keeps the block busy in the next cycle.
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.mode != MODE_NONE) |=> !req_ready)
		else $error("request taken while a previous one is in progress");

endmodule

bind calendar_queue_band_scheduler cqbs_checker u_cqbs_checker (.*);
